// ===== hw/rtl/gwni_pkg.sv =====
// Shared types and constants of the gradient-weighted nearest interpolator.
package gwni_pkg;

    localparam int MAX_REFS = 64;
    localparam int MAX_DIMS = 8;
    localparam int REF_AW   = 6;
    localparam int DIM_AW   = 3;
    localparam int SUM_W    = 48;
    localparam int ACC_W    = 56;
    localparam int MAG_W    = 48;

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_KNOWN  = 3'd1,
        CMD_PROBE  = 3'd2,
        CMD_REPORT = 3'd3,
        CMD_CLEAR  = 3'd4
    } gwni_cmd_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_REFS = 2'd1;
    localparam logic [1:0] ST_ZERO_VOL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_DRAIN,
        S_INTERP,
        S_INTERP_DRAIN,
        S_FINISH,
        S_DIV,
        S_EMIT
    } gwni_state_t;

    // tag that travels with each memory read through the term pipeline
    typedef struct packed {
        logic              fin;
        logic              first_k;
        logic              last_k;
        logic [DIM_AW-1:0] k;
        logic [REF_AW-1:0] idx;
    } gwni_tag_t;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [MAG_W-1:0] mag;
        gwni_tag_t        tag;
    } gwni_term_t;

endpackage

// ===== hw/rtl/gwni_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
module gwni_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/gwni_term_pipe.sv =====
// Term pipeline: dx, magnitudes, product, truncated Q32.16 magnitude.
module gwni_term_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              issue,
    input  gwni_pkg::gwni_tag_t issue_tag,
    input  logic [31:0]       issue_q,
    input  logic [31:0]       coord,
    input  logic [31:0]       grad,
    output gwni_pkg::gwni_term_t term
);

    logic                s1_v_reg, s2_v_reg, s3_v_reg;
    gwni_pkg::gwni_tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic [31:0]         s1_q_reg;
    logic [32:0]         s2_mdx_reg;
    logic [31:0]         s2_mg_reg;
    logic                s2_neg_reg, s3_neg_reg;
    logic [64:0]         s3_prod_reg;
    logic [32:0]         dx;
    logic [32:0]         mdx;
    logic [31:0]         mg;

    always_comb
    begin
        dx  = {s1_q_reg[31], s1_q_reg} - {coord[31], coord};
        mdx = dx[32] ? 33'(-dx) : dx;
        mg  = grad[31] ? 32'(-grad) : grad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg  <= issue_tag;
        s1_q_reg    <= issue_q;
        s2_tag_reg  <= s1_tag_reg;
        s2_mdx_reg  <= mdx;
        s2_mg_reg   <= mg;
        s2_neg_reg  <= dx[32] ^ grad[31];
        s3_tag_reg  <= s2_tag_reg;
        s3_neg_reg  <= s2_neg_reg;
        s3_prod_reg <= 65'(s2_mdx_reg) * 65'(s2_mg_reg);
    end

    assign term.valid = s3_v_reg;
    assign term.neg   = s3_neg_reg;
    assign term.mag   = s3_prod_reg[63:16];
    assign term.tag   = s3_tag_reg;

endmodule

// ===== hw/rtl/gwni_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit saturated result.
module gwni_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [47:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [47:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [47:0] dvs_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [48:0] trial;
    logic [48:0] diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[63]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[48])
            begin
                rem_next = diff[47:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[47:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = (quo_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo_reg[31:0];

endmodule

// ===== hw/rtl/gradient_weighted_nearest_interpolator.sv =====
// Top level: reference store, nearest-reference scan, extrapolation and report.
// Items arrive one dimension per transaction; a point ends on last_dim. A final
// query item scans every stored reference, one (reference, dimension) pair per
// cycle from the shared coordinate/gradient RAM. A report with a nonzero volume
// sum runs a one-bit-per-cycle divider. One item is worked at a time; a finished
// result waits in the output register and a new transaction is taken meanwhile.
// The memories need no clearing pass after reset. Unused num_dims codes: 0 acts
// as 1 and values above 8 act as 8.
module gradient_weighted_nearest_interpolator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [31:0] coordinate,
    input  logic [31:0] gradient,
    input  logic [31:0] sample_value,
    input  logic        last_dim,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [31:0] interpolated,
    output logic [5:0]  nearest_index,
    output logic [31:0] nearest_distance,
    output logic [31:0] ratio,
    output logic [1:0]  status
);

    localparam int AW = gwni_pkg::REF_AW + gwni_pkg::DIM_AW;

    gwni_pkg::gwni_state_t state_reg, state_next;

    logic [3:0]  num_dims_reg;
    logic [2:0]  nd_m1;
    logic [2:0]  dim_reg;
    logic [2:0]  d;
    logic [6:0]  count_reg;
    logic [47:0] err_sum_reg, vol_sum_reg;
    logic [31:0] query_reg [gwni_pkg::MAX_DIMS];
    logic [2:0]  cmd_reg;
    logic [31:0] known_reg;

    // scan and extrapolation
    logic [5:0]  scan_r_reg;
    logic [2:0]  scan_k_reg;
    logic [5:0]  best_reg;
    logic [32:0] best_dist_reg;
    logic [31:0] dist_reg;
    logic signed [gwni_pkg::ACC_W-1:0] acc_reg;

    // result staging
    logic        res_kind_reg;
    logic [31:0] res_interp_reg, res_ratio_reg;
    logic [1:0]  res_status_reg;

    // output register
    logic        out_valid_reg;
    logic        kind_reg;
    logic [31:0] interp_reg, dist_out_reg, ratio_reg;
    logic [5:0]  idx_reg;
    logic [1:0]  status_reg;

    logic        accept;
    logic        issue;
    logic        issue_last;
    logic        div_start;
    logic        emit;
    logic        scan_lastk;
    logic        scan_lastr;
    logic [AW-1:0] raddr;
    logic [63:0] cg_rdata;
    logic [31:0] val_rdata;
    gwni_pkg::gwni_tag_t  issue_tag;
    gwni_pkg::gwni_term_t term;
    logic        div_done;
    logic [31:0] div_q;
    logic [31:0] term_sat;
    logic [31:0] dist_new;
    logic signed [gwni_pkg::ACC_W-1:0] total;
    logic [31:0] interp_sat;
    logic signed [33:0] err_diff;
    logic [32:0] err_mag;
    logic [31:0] vol_mag;
    logic [48:0] err_add, vol_add;

    always_comb
    begin
        if (num_dims_reg == 4'd0)
        begin
            nd_m1 = 3'd0;
        end
        else if (num_dims_reg > 4'(gwni_pkg::MAX_DIMS))
        begin
            nd_m1 = 3'(gwni_pkg::MAX_DIMS - 1);
        end
        else
        begin
            nd_m1 = 3'(num_dims_reg - 4'd1);
        end
        d = (dim_reg < nd_m1) ? dim_reg : nd_m1;
    end

    assign accept     = in_valid && in_ready;
    assign scan_lastk = (scan_k_reg == nd_m1);
    assign scan_lastr = ({1'b0, scan_r_reg} == 7'(count_reg - 7'd1));
    assign cfg_ready  = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gwni_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    priority if (command == gwni_pkg::CMD_REPORT)
                    begin
                        state_next = (vol_sum_reg == '0) ? gwni_pkg::S_EMIT : gwni_pkg::S_DIV;
                    end
                    else if ((command == gwni_pkg::CMD_KNOWN ||
                              command == gwni_pkg::CMD_PROBE) && last_dim)
                    begin
                        state_next = (count_reg == '0) ? gwni_pkg::S_EMIT : gwni_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = gwni_pkg::S_IDLE;
                    end
                end
            end
            gwni_pkg::S_SCAN:
            begin
                if (scan_lastk && scan_lastr)
                begin
                    state_next = gwni_pkg::S_SCAN_DRAIN;
                end
            end
            gwni_pkg::S_SCAN_DRAIN:
            begin
                if (term.valid && term.tag.fin)
                begin
                    state_next = gwni_pkg::S_INTERP;
                end
            end
            gwni_pkg::S_INTERP:
            begin
                if (scan_lastk)
                begin
                    state_next = gwni_pkg::S_INTERP_DRAIN;
                end
            end
            gwni_pkg::S_INTERP_DRAIN:
            begin
                if (term.valid && term.tag.fin)
                begin
                    state_next = gwni_pkg::S_FINISH;
                end
            end
            gwni_pkg::S_FINISH:
            begin
                state_next = gwni_pkg::S_EMIT;
            end
            gwni_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = gwni_pkg::S_EMIT;
                end
            end
            gwni_pkg::S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = gwni_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gwni_pkg::S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready   = (state_reg == gwni_pkg::S_IDLE);
        issue      = (state_reg == gwni_pkg::S_SCAN) || (state_reg == gwni_pkg::S_INTERP);
        issue_last = scan_lastk && (state_reg == gwni_pkg::S_INTERP || scan_lastr);
        div_start  = accept && (command == gwni_pkg::CMD_REPORT) && (vol_sum_reg != '0);
        emit       = (state_reg == gwni_pkg::S_EMIT) && (!out_valid_reg || out_ready);
    end

    assign issue_tag.fin     = issue_last;
    assign issue_tag.first_k = (scan_k_reg == 3'd0);
    assign issue_tag.last_k  = scan_lastk;
    assign issue_tag.k       = scan_k_reg;
    assign issue_tag.idx     = scan_r_reg;
    assign raddr = (state_reg == gwni_pkg::S_INTERP) ? {best_reg, scan_k_reg}
                                                     : {scan_r_reg, scan_k_reg};

    // coordinate and gradient per (reference, dimension)
    gwni_ram #(.DATA_W(64), .ADDR_W(AW)) u_cg_ram (
        .clk   (clk),
        .we    (accept && command == gwni_pkg::CMD_LOAD && !count_reg[6]),
        .waddr ({count_reg[5:0], d}),
        .wdata ({coordinate, gradient}),
        .raddr (raddr),
        .rdata (cg_rdata)
    );

    // output value per reference
    gwni_ram #(.DATA_W(32), .ADDR_W(gwni_pkg::REF_AW)) u_val_ram (
        .clk   (clk),
        .we    (accept && command == gwni_pkg::CMD_LOAD && !count_reg[6] && last_dim),
        .waddr (count_reg[5:0]),
        .wdata (sample_value),
        .raddr (best_reg),
        .rdata (val_rdata)
    );

    gwni_term_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .issue_tag (issue_tag),
        .issue_q   (query_reg[scan_k_reg]),
        .coord     (cg_rdata[63:32]),
        .grad      (cg_rdata[31:0]),
        .term      (term)
    );

    gwni_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({err_sum_reg, 16'd0}),
        .divisor  (vol_sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // distance and extrapolation arithmetic
    always_comb
    begin
        term_sat = (term.mag[47:32] != 16'd0) ? 32'hFFFF_FFFF : term.mag[31:0];
        if (term.tag.first_k || term_sat > dist_reg)
        begin
            dist_new = term_sat;
        end
        else
        begin
            dist_new = dist_reg;
        end
        total = acc_reg + gwni_pkg::ACC_W'($signed(val_rdata));
        if (total > $signed(gwni_pkg::ACC_W'(32'h7FFF_FFFF)))
        begin
            interp_sat = 32'h7FFF_FFFF;
        end
        else if (total < -$signed(gwni_pkg::ACC_W'(33'h0_8000_0000)))
        begin
            interp_sat = 32'h8000_0000;
        end
        else
        begin
            interp_sat = total[31:0];
        end
        err_diff = 34'($signed(known_reg)) - 34'($signed(interp_sat));
        err_mag  = err_diff[33] ? 33'(-err_diff) : err_diff[32:0];
        vol_mag  = known_reg[31] ? 32'(-known_reg) : known_reg;
        err_add  = {1'b0, err_sum_reg} + 49'(err_mag);
        vol_add  = {1'b0, vol_sum_reg} + 49'(vol_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gwni_pkg::S_IDLE;
            num_dims_reg  <= 4'd1;
            dim_reg       <= '0;
            count_reg     <= '0;
            err_sum_reg   <= '0;
            vol_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                num_dims_reg <= cfg_data;
            end
            if (accept)
            begin
                if (command == gwni_pkg::CMD_CLEAR)
                begin
                    dim_reg     <= '0;
                    count_reg   <= '0;
                    err_sum_reg <= '0;
                    vol_sum_reg <= '0;
                end
                else if (command == gwni_pkg::CMD_LOAD || command == gwni_pkg::CMD_KNOWN ||
                         command == gwni_pkg::CMD_PROBE)
                begin
                    if (!last_dim)
                    begin
                        dim_reg <= (d < nd_m1) ? 3'(d + 3'd1) : d;
                    end
                    else
                    begin
                        dim_reg <= '0;
                    end
                    if (command == gwni_pkg::CMD_LOAD && last_dim && !count_reg[6])
                    begin
                        count_reg <= count_reg + 7'd1;
                    end
                end
            end
            if (state_reg == gwni_pkg::S_FINISH && cmd_reg == gwni_pkg::CMD_KNOWN)
            begin
                err_sum_reg <= err_add[48] ? 48'hFFFF_FFFF_FFFF : err_add[47:0];
                vol_sum_reg <= vol_add[48] ? 48'hFFFF_FFFF_FFFF : vol_add[47:0];
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            known_reg <= sample_value;
            if (command == gwni_pkg::CMD_KNOWN || command == gwni_pkg::CMD_PROBE)
            begin
                query_reg[d] <= coordinate;
            end
            scan_r_reg     <= '0;
            scan_k_reg     <= '0;
            best_reg       <= '0;
            best_dist_reg  <= 33'h1_0000_0000;
            res_kind_reg   <= (command == gwni_pkg::CMD_REPORT);
            res_interp_reg <= '0;
            res_ratio_reg  <= '0;
            res_status_reg <= (command == gwni_pkg::CMD_REPORT) ? gwni_pkg::ST_ZERO_VOL
                                                                : gwni_pkg::ST_NO_REFS;
        end
        if (issue)
        begin
            if (scan_lastk)
            begin
                scan_k_reg <= '0;
                scan_r_reg <= 6'(scan_r_reg + 6'd1);
            end
            else
            begin
                scan_k_reg <= scan_k_reg + 3'd1;
            end
        end
        if (state_reg == gwni_pkg::S_SCAN_DRAIN && state_next == gwni_pkg::S_INTERP)
        begin
            acc_reg <= '0;
        end
        if (term.valid)
        begin
            if (state_reg == gwni_pkg::S_SCAN || state_reg == gwni_pkg::S_SCAN_DRAIN)
            begin
                dist_reg <= dist_new;
                if (term.tag.last_k && {1'b0, dist_new} < best_dist_reg)
                begin
                    best_dist_reg <= {1'b0, dist_new};
                    best_reg      <= term.tag.idx;
                end
            end
            else
            begin
                acc_reg <= term.neg ? acc_reg - gwni_pkg::ACC_W'(term.mag)
                                    : acc_reg + gwni_pkg::ACC_W'(term.mag);
            end
        end
        if (state_reg == gwni_pkg::S_FINISH)
        begin
            res_interp_reg <= interp_sat;
            res_status_reg <= gwni_pkg::ST_OK;
        end
        if (state_reg == gwni_pkg::S_DIV && div_done)
        begin
            res_ratio_reg  <= div_q;
            res_status_reg <= gwni_pkg::ST_OK;
        end
        if (emit)
        begin
            kind_reg     <= res_kind_reg;
            interp_reg   <= res_interp_reg;
            ratio_reg    <= res_ratio_reg;
            status_reg   <= res_status_reg;
            idx_reg      <= (res_status_reg == gwni_pkg::ST_OK && !res_kind_reg) ? best_reg : '0;
            dist_out_reg <= (res_status_reg == gwni_pkg::ST_OK && !res_kind_reg)
                            ? best_dist_reg[31:0] : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = kind_reg;
    assign interpolated     = interp_reg;
    assign nearest_index    = idx_reg;
    assign nearest_distance = dist_out_reg;
    assign ratio            = ratio_reg;
    assign status           = status_reg;

    // the store never holds more than its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 7'(gwni_pkg::MAX_REFS))
        else $error("reference count beyond capacity");

    // pipeline terms only appear while a scan or extrapolation is running
    assert property (@(posedge clk) disable iff (!rst_n)
        term.valid |-> (state_reg == gwni_pkg::S_SCAN || state_reg == gwni_pkg::S_SCAN_DRAIN ||
                        state_reg == gwni_pkg::S_INTERP ||
                        state_reg == gwni_pkg::S_INTERP_DRAIN))
        else $error("stray pipeline term");

    // the chosen reference is one that is stored
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gwni_pkg::S_INTERP) |-> ({1'b0, best_reg} < count_reg))
        else $error("nearest index outside store");

endmodule

// ===== sim/gradient_weighted_nearest_interpolator_tb.sv =====
// Self-checking testbench of the gradient-weighted nearest interpolator.
module gradient_weighted_nearest_interpolator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [31:0] coordinate;
    logic [31:0] gradient;
    logic [31:0] sample_value;
    logic        last_dim;
    logic        out_valid;
    logic        out_ready;
    logic        result_kind;
    logic [31:0] interpolated;
    logic [5:0]  nearest_index;
    logic [31:0] nearest_distance;
    logic [31:0] ratio;
    logic [1:0]  status;

    gradient_weighted_nearest_interpolator DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .coordinate       (coordinate),
        .gradient         (gradient),
        .sample_value     (sample_value),
        .last_dim         (last_dim),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_kind      (result_kind),
        .interpolated     (interpolated),
        .nearest_index    (nearest_index),
        .nearest_distance (nearest_distance),
        .ratio            (ratio),
        .status           (status)
    );

    typedef struct packed {
        logic        kind;
        logic [31:0] interp;
        logic [5:0]  idx;
        logic [31:0] distance;
        logic [31:0] ratio;
        logic [1:0]  status;
    } lookup_result_t;

    localparam logic [47:0] SUM_LIMIT = 48'hFFFF_FFFF_FFFF;

    // Shadow of the block's state
    logic [31:0] shadow_coord [gwni_pkg::MAX_REFS*gwni_pkg::MAX_DIMS];
    logic [31:0] shadow_grad  [gwni_pkg::MAX_REFS*gwni_pkg::MAX_DIMS];
    logic [31:0] shadow_value [gwni_pkg::MAX_REFS];
    logic [31:0] shadow_query [gwni_pkg::MAX_DIMS];
    int          stored_refs;
    int          dim_pos;
    logic [47:0] err_total;
    logic [47:0] vol_total;
    logic [3:0]  dims_reg;

    lookup_result_t pending_results [$];
    int  mismatch_count;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int active_dims();
        if (dims_reg == 0)
            return 1;
        if (dims_reg > gwni_pkg::MAX_DIMS)
            return gwni_pkg::MAX_DIMS;
        return int'(dims_reg);
    endfunction

    function automatic logic [63:0] magnitude(longint x);
        return (x < 0) ? -x : x;
    endfunction

    // truncated |dx*g| >> 16; |dx| < 2^33, |g| <= 2^31 so the product fits 64 bits
    function automatic logic [63:0] scaled_product(longint dx, longint g);
        logic [63:0] p;
        p = magnitude(dx) * magnitude(g);
        return p >> 16;
    endfunction

    function automatic logic [47:0] add_capped(logic [47:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > SUM_LIMIT) ? SUM_LIMIT : s[47:0];
    endfunction

    // Advances the shadow state by one item; returns 1 when a result is due.
    function automatic bit predict_item(logic [2:0] cmd, logic [31:0] crd, logic [31:0] grd,
                                        logic [31:0] val, logic lst,
                                        output lookup_result_t res);
        int nd, d, best, base;
        logic [63:0] best_dist, ref_dist, m, q;
        longint dx, g, acc, t;
        nd  = active_dims();
        d   = (dim_pos < nd) ? dim_pos : nd - 1;
        res = '0;
        if (cmd == gwni_pkg::CMD_REPORT) begin
            res.kind = 1'b1;
            if (vol_total == 0)
                res.status = gwni_pkg::ST_ZERO_VOL;
            else begin
                q = ({16'd0, err_total} << 16) / vol_total;
                res.ratio  = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                res.status = gwni_pkg::ST_OK;
            end
            return 1;
        end
        if (cmd == gwni_pkg::CMD_CLEAR) begin
            stored_refs = 0;
            dim_pos     = 0;
            err_total   = 0;
            vol_total   = 0;
            return 0;
        end
        if (cmd > gwni_pkg::CMD_CLEAR)
            return 0;
        if (cmd == gwni_pkg::CMD_LOAD) begin
            if (stored_refs < gwni_pkg::MAX_REFS) begin
                shadow_coord[stored_refs*gwni_pkg::MAX_DIMS + d] = crd;
                shadow_grad[stored_refs*gwni_pkg::MAX_DIMS + d]  = grd;
                if (lst) begin
                    shadow_value[stored_refs] = val;
                    stored_refs++;
                end
            end
        end else
            shadow_query[d] = crd;
        if (!lst) begin
            dim_pos = (d + 1 < nd) ? d + 1 : d;
            return 0;
        end
        dim_pos = 0;
        if (cmd == gwni_pkg::CMD_LOAD)
            return 0;
        if (stored_refs == 0) begin
            res.status = gwni_pkg::ST_NO_REFS;
            return 1;
        end
        best      = 0;
        best_dist = 64'h1_0000_0000;
        for (int r = 0; r < stored_refs; r++) begin
            ref_dist = 0;
            for (int k = 0; k < nd; k++) begin
                dx = longint'($signed(shadow_query[k])) -
                     longint'($signed(shadow_coord[r*gwni_pkg::MAX_DIMS + k]));
                m  = scaled_product(dx,
                         longint'($signed(shadow_grad[r*gwni_pkg::MAX_DIMS + k])));
                if (m > 64'hFFFF_FFFF)
                    m = 64'hFFFF_FFFF;
                if (m > ref_dist)
                    ref_dist = m;
            end
            if (ref_dist < best_dist) begin
                best_dist = ref_dist;
                best      = r;
            end
        end
        base = best*gwni_pkg::MAX_DIMS;
        acc  = longint'($signed(shadow_value[best]));
        for (int k = 0; k < nd; k++) begin
            dx  = longint'($signed(shadow_query[k])) - longint'($signed(shadow_coord[base + k]));
            g   = longint'($signed(shadow_grad[base + k]));
            t   = longint'(scaled_product(dx, g));
            acc = ((dx < 0) != (g < 0)) ? acc - t : acc + t;
        end
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        if (cmd == gwni_pkg::CMD_KNOWN) begin
            err_total = add_capped(err_total, magnitude(longint'($signed(val)) - acc));
            vol_total = add_capped(vol_total, magnitude(longint'($signed(val))));
        end
        res.interp   = acc[31:0];
        res.idx      = best[5:0];
        res.distance = best_dist[31:0];
        return 1;
    endfunction

    // Sends one item after a random gap, logging the expected result if any.
    // Valid stays high across a zero gap; returns just after a falling edge.
    task automatic send_item(logic [2:0] cmd, logic [31:0] crd, logic [31:0] grd,
                             logic [31:0] val, logic lst);
        lookup_result_t res;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        coordinate   <= crd;
        gradient     <= grd;
        sample_value <= val;
        last_dim     <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        if (predict_item(cmd, crd, grd, val, lst, res))
            pending_results.push_back(res);
        @(negedge clk);
    endtask

    // Waits for the block to drain, then writes num_dims.
    task automatic write_dims(logic [3:0] value);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (600) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        dims_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    // A whole point with one command; n items with last_dim on the final one.
    task automatic send_point(logic [2:0] cmd, int n);
        for (int i = 0; i < n; i++)
            send_item(cmd, random_word(), random_word(), random_word(), i == n - 1);
    endtask

    task automatic test_directed();
        send_point(gwni_pkg::CMD_PROBE, 1);                   // query with no references
        send_item(gwni_pkg::CMD_REPORT, 0, 0, 0, 1'b0);       // zero volume
        send_item(gwni_pkg::CMD_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_item(gwni_pkg::CMD_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_item(gwni_pkg::CMD_LOAD, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b1);
        send_item(gwni_pkg::CMD_KNOWN, 32'h7FFF_FFFF, 0, 32'h8000_0000, 1'b1);
        send_item(gwni_pkg::CMD_KNOWN, 32'h8000_0000, 0, 32'h7FFF_FFFF, 1'b1);
        send_item(gwni_pkg::CMD_PROBE, 32'h0001_0000, 0, 0, 1'b1); // refs 0 and 1 tie saturated; ref 2 is nearest
        send_item(gwni_pkg::CMD_REPORT, 0, 0, 0, 1'b1);
        send_item(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(3'd7, 0, 0, 0, 1'b0);
        send_item(gwni_pkg::CMD_CLEAR, 0, 0, 0, 1'b0);
        send_item(gwni_pkg::CMD_REPORT, 0, 0, 0, 1'b1);
    endtask

    // Multi-dimension points, including short and over-long ones and mixed commands.
    task automatic test_dimensions(logic [3:0] dims);
        int nd;
        write_dims(dims);
        nd = active_dims();
        send_item(gwni_pkg::CMD_CLEAR, 0, 0, 0, 1'b1);
        for (int p = 0; p < 4; p++)
            send_point(gwni_pkg::CMD_LOAD, nd);
        send_point(gwni_pkg::CMD_KNOWN, nd);
        send_point(gwni_pkg::CMD_PROBE, nd + 2);      // extras overwrite last dimension
        send_point(gwni_pkg::CMD_KNOWN, 1);           // short point keeps old query dims
        send_item(gwni_pkg::CMD_PROBE, random_word(), 0, 0, 1'b0);
        send_item(gwni_pkg::CMD_KNOWN, random_word(), 0, random_word(), 1'b1);
        send_item(gwni_pkg::CMD_REPORT, 0, 0, 0, 1'b1);
    endtask

    task automatic test_full_store();
        write_dims(4'd1);
        send_item(gwni_pkg::CMD_CLEAR, 0, 0, 0, 1'b1);
        for (int i = 0; i < gwni_pkg::MAX_REFS + 3; i++)
            send_point(gwni_pkg::CMD_LOAD, 1);
        send_point(gwni_pkg::CMD_KNOWN, 1);
        send_point(gwni_pkg::CMD_PROBE, 1);
    endtask

    // Mostly well-formed points with random content, plus noise. Loads always
    // cover every dimension so that no reference slot is read unwritten.
    task automatic test_random(int items);
        int sent, sel, nd, n;
        logic [3:0] dims;
        sent = 0;
        while (sent < items) begin
            if (sent % 130 == 0) begin
                dims = 4'($urandom_range(0, 15));
                write_dims(dims);
                send_item(gwni_pkg::CMD_CLEAR, 0, 0, 0, 1'b0);
                sent++;
            end
            nd  = active_dims();
            sel = $urandom_range(0, 99);
            n   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, nd + 2) : nd;
            if (stored_refs == 0 || sel < 30) begin
                if (n < nd)
                    n = nd;
                send_point(gwni_pkg::CMD_LOAD, n);
                sent += n;
            end else if (sel < 70) begin
                send_point(gwni_pkg::CMD_KNOWN, n);
                sent += n;
            end else if (sel < 85) begin
                send_point(gwni_pkg::CMD_PROBE, n);
                sent += n;
            end else if (sel < 93) begin
                send_item(gwni_pkg::CMD_REPORT, random_word(), 0, 0, 1'($urandom_range(0, 1)));
                sent++;
            end else if (sel < 95) begin
                send_item(gwni_pkg::CMD_CLEAR, 0, 0, 0, 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                send_item(3'($urandom_range(5, 7)), random_word(), random_word(),
                          random_word(), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // Result side: random stalls, compare each transaction with the oldest expectation.
    initial
    begin
        lookup_result_t want, got;
        int stall;
        out_ready = 1'b0;
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got = '{result_kind, interpolated, nearest_index, nearest_distance, ratio, status};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: kind %0d/%0d interp %h/%h idx %0d/%0d",
                                  " dist %h/%h ratio %h/%h status %0d/%0d"},
                                 want.kind, got.kind, want.interp, got.interp,
                                 want.idx, got.idx, want.distance, got.distance,
                                 want.ratio, got.ratio, want.status, got.status);
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        command      = gwni_pkg::CMD_LOAD;
        coordinate   = '0;
        gradient     = '0;
        sample_value = '0;
        last_dim     = 1'b0;
        stored_refs  = 0;
        dim_pos      = 0;
        err_total    = 0;
        vol_total    = 0;
        dims_reg     = 4'd1;
        mismatch_count = 0;
        rst_n        = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_dimensions(4'd8);
        test_dimensions(4'd0);
        test_dimensions(4'd15);
        test_dimensions(4'd3);
        test_full_store();
        test_random(300);

        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (700) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("gradient_weighted_nearest_interpolator verification clean");
        else
            $display("gradient_weighted_nearest_interpolator verification failed");
        $finish;
    end

    // Watchdog: worst case is far below this.
    initial
    begin
        #20ms;
        $display("gradient_weighted_nearest_interpolator verification failed");
        $finish;
    end

endmodule
